>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/hcbd_pkg.sv
// Types, character codes and helpers for the chunked body decoder.
// No dependencies; used by the line parser, the core and the checker.
package hcbd_pkg;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_DONE      = 3'd1,
    KIND_MALFORMED = 3'd2,
    KIND_TRAILER   = 3'd3,
    KIND_AFTER     = 3'd4
  } kind_e;

  // Progress through a size line.
  typedef enum logic [2:0] {
    LINE_BLANK  = 3'd0,
    LINE_ZERO   = 3'd1,
    LINE_DIGITS = 3'd2,
    LINE_IGN    = 3'd3,
    LINE_IGN_CR = 3'd4,
    LINE_BAD    = 3'd5,
    LINE_BAD_CR = 3'd6
  } line_e;

  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_SP      = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_VT      = 8'h0B;
  localparam logic [7:0] CHAR_FF      = 8'h0C;
  localparam logic [7:0] CHAR_LOWER_X = 8'h78;
  localparam logic [7:0] CHAR_UPPER_X = 8'h58;

  // Parser verdict on one size-line byte.
  typedef struct packed {
    line_e line_next;
    logic  digit_seen_next;
    logic  line_done;
    logic  malformed;
  } line_res_t;

  // Bit 4 flags a hex digit, bits 3:0 give its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

>>> sv/hcbd_line_parser.sv
// Combinational step of the chunk-size line parser: hex accumulate, prefix
// and blank skipping, CR LF detection. Depends on hcbd_pkg.
module hcbd_line_parser #(
  parameter int LENGTH_WIDTH = 32
) (
  input  logic [7:0]              data_i,
  input  hcbd_pkg::line_e         line_i,
  input  logic                    digit_seen_i,
  input  logic [LENGTH_WIDTH-1:0] len_i,
  output logic [LENGTH_WIDTH-1:0] len_o,
  output hcbd_pkg::line_res_t     res_o
);

  logic       ignoring;
  logic       bad;
  logic       after_cr;
  logic       blank;
  logic [4:0] hex;
  logic       overflow;

  assign ignoring = (line_i == hcbd_pkg::LINE_IGN)    || (line_i == hcbd_pkg::LINE_IGN_CR) ||
                    (line_i == hcbd_pkg::LINE_BAD)    || (line_i == hcbd_pkg::LINE_BAD_CR);
  assign bad      = (line_i == hcbd_pkg::LINE_BAD)    || (line_i == hcbd_pkg::LINE_BAD_CR);
  assign after_cr = (line_i == hcbd_pkg::LINE_IGN_CR) || (line_i == hcbd_pkg::LINE_BAD_CR);
  assign blank    = (data_i == hcbd_pkg::CHAR_SP) || (data_i == hcbd_pkg::CHAR_TAB) ||
                    (data_i == hcbd_pkg::CHAR_VT) || (data_i == hcbd_pkg::CHAR_FF);
  assign hex      = hcbd_pkg::hex_decode(data_i);
  assign overflow = (len_i[LENGTH_WIDTH-1 -: 4] != 4'd0);

  always_comb begin
    len_o                 = len_i;
    res_o.line_next       = line_i;
    res_o.digit_seen_next = digit_seen_i;
    res_o.line_done       = 1'b0;
    res_o.malformed       = 1'b0;
    priority if (ignoring) begin
      if (data_i == hcbd_pkg::CHAR_LF && after_cr) begin
        res_o.line_next = hcbd_pkg::LINE_BLANK;
        if (bad || !digit_seen_i) begin
          res_o.malformed = 1'b1;
        end else begin
          res_o.line_done = 1'b1;
        end
      end else if (data_i == hcbd_pkg::CHAR_CR) begin
        res_o.line_next = bad ? hcbd_pkg::LINE_BAD_CR : hcbd_pkg::LINE_IGN_CR;
      end else begin
        res_o.line_next = bad ? hcbd_pkg::LINE_BAD : hcbd_pkg::LINE_IGN;
      end
    end else if (data_i == hcbd_pkg::CHAR_CR) begin
      res_o.line_next = hcbd_pkg::LINE_IGN_CR;
    end else if (line_i == hcbd_pkg::LINE_BLANK && blank) begin
      res_o.line_next = line_i;
    end else if (line_i == hcbd_pkg::LINE_ZERO &&
                 (data_i == hcbd_pkg::CHAR_LOWER_X || data_i == hcbd_pkg::CHAR_UPPER_X)) begin
      res_o.line_next = hcbd_pkg::LINE_DIGITS;
    end else if (!hex[4]) begin
      res_o.line_next = hcbd_pkg::LINE_IGN;
    end else if (overflow) begin
      res_o.line_next = hcbd_pkg::LINE_BAD;
    end else begin
      len_o = {len_i[LENGTH_WIDTH-5:0], hex[3:0]};
      // a single leading zero may open an 0x prefix
      res_o.line_next = (line_i == hcbd_pkg::LINE_BLANK && hex[3:0] == 4'd0 && !digit_seen_i)
                        ? hcbd_pkg::LINE_ZERO : hcbd_pkg::LINE_DIGITS;
      res_o.digit_seen_next = 1'b1;
    end
  end

endmodule

>>> sv/http_chunked_body_decoder_core.sv
// Decodes an HTTP chunked body one byte per item: size lines, payload
// pass-through, chunk trailers. Throughput is one byte per clock cycle while
// the result is not stalled; a byte goes from the input register through one
// state-update step (hex shift-accumulate or a LENGTH_WIDTH-bit decrement)
// into the result register. A stalled result holds the input register and
// stalls the input.
// Depends on hcbd_pkg and hcbd_line_parser.
module http_chunked_body_decoder_core #(
  parameter int LENGTH_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            kind_o,
  output logic [7:0]            payload_o
);

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_DATA,
    PH_TRAIL,
    PH_LAST,
    PH_ENDED,
    PH_HALT
  } phase_e;

  logic                    in_valid_q;
  logic [7:0]              in_data_q;
  phase_e                  phase_q, phase_d;
  logic [LENGTH_WIDTH-1:0] len_q, len_d;
  hcbd_pkg::line_e         line_q, line_d;
  logic                    digit_seen_q, digit_seen_d;
  logic                    trail_pos_q, trail_pos_d;
  logic                    trail_ok_q, trail_ok_d;
  logic                    out_valid_q, out_valid_d;
  hcbd_pkg::kind_e         kind_q, kind_d;
  logic [7:0]              payload_q, payload_d;

  logic                    advance;
  logic                    emit;
  logic [LENGTH_WIDTH-1:0] parse_len;
  hcbd_pkg::line_res_t     parse_res;
  logic [LENGTH_WIDTH-1:0] len_dec;

  assign advance    = !out_valid_q || !out_stall_i;
  // the input register only loads when the pipeline advances
  assign in_stall_o = !advance;
  assign len_dec    = len_q - LENGTH_WIDTH'(1);

  hcbd_line_parser #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_parser (
    .data_i       (in_data_q),
    .line_i       (line_q),
    .digit_seen_i (digit_seen_q),
    .len_i        (len_q),
    .len_o        (parse_len),
    .res_o        (parse_res)
  );

  always_comb begin
    phase_d      = phase_q;
    len_d        = len_q;
    line_d       = line_q;
    digit_seen_d = digit_seen_q;
    trail_pos_d  = trail_pos_q;
    trail_ok_d   = trail_ok_q;
    emit         = 1'b0;
    kind_d       = hcbd_pkg::KIND_PAYLOAD;
    payload_d    = 8'd0;
    unique case (phase_q)
      PH_SIZE: begin
        line_d       = parse_res.line_next;
        digit_seen_d = parse_res.digit_seen_next;
        len_d        = parse_len;
        if (parse_res.malformed) begin
          phase_d = PH_HALT;
          emit    = 1'b1;
          kind_d  = hcbd_pkg::KIND_MALFORMED;
        end else if (parse_res.line_done) begin
          phase_d     = (len_q == '0) ? PH_LAST : PH_DATA;
          trail_pos_d = 1'b0;
          trail_ok_d  = 1'b0;
        end
      end
      PH_DATA: begin
        len_d     = len_dec;
        emit      = 1'b1;
        payload_d = in_data_q;
        if (len_dec == '0) begin
          phase_d     = PH_TRAIL;
          trail_pos_d = 1'b0;
          trail_ok_d  = 1'b0;
        end
      end
      PH_TRAIL, PH_LAST: begin
        if (!trail_pos_q) begin
          trail_ok_d  = (in_data_q == hcbd_pkg::CHAR_CR);
          trail_pos_d = 1'b1;
        end else begin
          trail_pos_d = 1'b0;
          if (phase_q == PH_LAST) begin
            phase_d = PH_ENDED;
            emit    = 1'b1;
            kind_d  = hcbd_pkg::KIND_DONE;
          end else begin
            // start the next size line
            phase_d      = PH_SIZE;
            len_d        = '0;
            line_d       = hcbd_pkg::LINE_BLANK;
            digit_seen_d = 1'b0;
            if (!(trail_ok_q && in_data_q == hcbd_pkg::CHAR_LF)) begin
              emit   = 1'b1;
              kind_d = hcbd_pkg::KIND_TRAILER;
            end
          end
        end
      end
      PH_ENDED: begin
        emit   = 1'b1;
        kind_d = hcbd_pkg::KIND_AFTER;
      end
      PH_HALT: begin
        emit = 1'b0;
      end
      default: begin
        phase_d = PH_HALT;
      end
    endcase
    out_valid_d = in_valid_q && emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= PH_SIZE;
      len_q        <= '0;
      line_q       <= hcbd_pkg::LINE_BLANK;
      digit_seen_q <= 1'b0;
      trail_pos_q  <= 1'b0;
      trail_ok_q   <= 1'b0;
    end else if (advance) begin
      in_valid_q  <= in_valid_i;
      out_valid_q <= out_valid_d;
      if (in_valid_q) begin
        phase_q      <= phase_d;
        len_q        <= len_d;
        line_q       <= line_d;
        digit_seen_q <= digit_seen_d;
        trail_pos_q  <= trail_pos_d;
        trail_ok_q   <= trail_ok_d;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (advance) begin
      in_data_q <= data_byte_i;
      if (out_valid_d) begin
        kind_q    <= kind_d;
        payload_q <= payload_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign payload_o   = payload_q;

endmodule

>>> sv/hcbd_checker.sv
// Port-level checks on the chunked body decoder's result channel.
// Depends on hcbd_pkg and assert_macros.svh; bound to the core below.
`include "assert_macros.svh"

module hcbd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] kind_o,
  input logic [7:0] payload_o
);

  logic take;
  logic halted_q;
  logic ended_q;

  assign take = out_valid_o && !out_stall_i;

  // remember a taken malformed report and a taken end of body
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
      ended_q  <= 1'b0;
    end else begin
      if (take && kind_o == hcbd_pkg::KIND_MALFORMED) begin
        halted_q <= 1'b1;
      end
      if (take && kind_o == hcbd_pkg::KIND_DONE) begin
        ended_q <= 1'b1;
      end
    end
  end

  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(kind_o) && $stable(payload_o))
  `ASSERT_IMPLIES(a_payload_zero, clk_i, rst_ni, out_valid_o && kind_o != hcbd_pkg::KIND_PAYLOAD, payload_o == 8'd0)
  `ASSERT_IMPLIES(a_silent_after_halt, clk_i, rst_ni, halted_q, !out_valid_o)
  `ASSERT_IMPLIES(a_only_after_end, clk_i, rst_ni, ended_q && out_valid_o, kind_o == hcbd_pkg::KIND_AFTER)

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .payload_o   (payload_o)
);
